@@ hw/rtl/mmmd_pkg.sv @@
// Shared constants and types for the max-min Manhattan distance core.
package mmmd_pkg;

  localparam int MAX_SIDE    = 64;
  localparam int MAX_POINTS  = 4096;
  localparam int COORD_W     = $clog2(MAX_SIDE);
  localparam int SIDE_W      = COORD_W + 1;
  localparam int ADDR_W      = $clog2(MAX_POINTS);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int DIST_W      = CNT_W;
  localparam int N_CELLS     = 16;
  localparam int CELL_IDX_W  = $clog2(N_CELLS);
  localparam int BASE_W      = CNT_W + 1;
  localparam int DATA_W      = 32;
  localparam int PADDR_W     = 3;

  localparam logic [1:0] KIND_SOURCE = 2'd1;
  localparam logic [1:0] KIND_PLAIN  = 2'd2;
  localparam logic [1:0] KIND_TARGET = 2'd3;
  localparam logic [1:0] KIND_NONE   = 2'd0;

  localparam logic REG_GRID_SIDE = 1'b0;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [DIST_W-1:0]  best;
  } src_rec_t;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } tgt_t;

endpackage

@@ hw/rtl/mmmd_cell.sv @@
// One chain cell: holds a source point and its nearest target distance so far.
module mmmd_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  mmmd_pkg::src_rec_t rec_in,
  output mmmd_pkg::src_rec_t rec_out,
  input  mmmd_pkg::tgt_t    tgt_in,
  output mmmd_pkg::tgt_t    tgt_out
);

  mmmd_pkg::src_rec_t rec;
  mmmd_pkg::tgt_t     tgt;
  logic [mmmd_pkg::COORD_W-1:0] dx;
  logic [mmmd_pkg::COORD_W-1:0] dy;
  logic [mmmd_pkg::COORD_W:0]   dsum;

  always_comb begin
    dx   = (rec.x > tgt_in.x) ? rec.x - tgt_in.x : tgt_in.x - rec.x;
    dy   = (rec.y > tgt_in.y) ? rec.y - tgt_in.y : tgt_in.y - rec.y;
    dsum = {1'b0, dx} + {1'b0, dy};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec.valid <= 1'b0;
      tgt.valid <= 1'b0;
    end else begin
      tgt <= tgt_in;
      if (shift) begin
        rec <= rec_in;
      end else if (tgt_in.valid && rec.valid &&
                   ({{(mmmd_pkg::DIST_W-mmmd_pkg::COORD_W-1){1'b0}}, dsum} < rec.best)) begin
        rec.best <= {{(mmmd_pkg::DIST_W-mmmd_pkg::COORD_W-1){1'b0}}, dsum};
      end
    end
  end

  assign rec_out = rec;
  assign tgt_out = tgt;

endmodule

@@ hw/rtl/mmmd_chain.sv @@
// Row of cells: source records shift through, targets stream past every cell.
module mmmd_chain (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  mmmd_pkg::src_rec_t rec_in,
  output mmmd_pkg::src_rec_t rec_out,
  input  mmmd_pkg::tgt_t    tgt_in
);

  mmmd_pkg::src_rec_t rec_link [mmmd_pkg::N_CELLS+1];
  mmmd_pkg::tgt_t     tgt_link [mmmd_pkg::N_CELLS+1];

  assign rec_link[0] = rec_in;
  assign tgt_link[0] = tgt_in;

  for (genvar i = 0; i < mmmd_pkg::N_CELLS; i++) begin : g_cell
    mmmd_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (shift),
      .rec_in  (rec_link[i]),
      .rec_out (rec_link[i+1]),
      .tgt_in  (tgt_link[i]),
      .tgt_out (tgt_link[i+1])
    );
  end

  assign rec_out = rec_link[mmmd_pkg::N_CELLS];

endmodule

@@ hw/rtl/max_min_manhattan_distance_core.sv @@
// Top level: grid loader, point stores, search sequencer and APB register.
//
// Cells are taken one per cycle while busy is low; busy rises after the last
// cell of a grid and the search runs. The search loads sources into a chain of
// N_CELLS (16) cells in batches and streams every target past each batch, reading
// each point store through its single read port. The result is shown for one
// cycle with done high and cannot be held off.
module max_min_manhattan_distance_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [1:0]                        cell_kind,
  output logic                              busy,
  output logic                              done,
  output logic [mmmd_pkg::DIST_W-1:0]       max_min_distance,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mmmd_pkg::PADDR_W-1:0]      paddr,
  input  logic [mmmd_pkg::DATA_W-1:0]       pwdata,
  output logic [mmmd_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LOAD   = 6'b000010,
    ST_STREAM = 6'b000100,
    ST_WAIT   = 6'b001000,
    ST_SETTLE = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t state;

  logic [mmmd_pkg::SIDE_W-1:0]  grid_side;
  logic [mmmd_pkg::SIDE_W-1:0]  side_eff;
  logic [mmmd_pkg::DIST_W-1:0]  side_sq;
  logic [mmmd_pkg::COORD_W-1:0] col;
  logic [mmmd_pkg::COORD_W-1:0] row;
  logic [mmmd_pkg::SIDE_W-1:0]  col_inc;
  logic [mmmd_pkg::SIDE_W-1:0]  row_inc;
  logic [mmmd_pkg::CNT_W-1:0]   scount;
  logic [mmmd_pkg::CNT_W-1:0]   tcount;
  logic [mmmd_pkg::BASE_W-1:0]  base;
  logic [mmmd_pkg::BASE_W-1:0]  src_idx;
  logic [mmmd_pkg::CELL_IDX_W-1:0] kcnt;
  logic [mmmd_pkg::CNT_W-1:0]   tcnt;
  logic [mmmd_pkg::CELL_IDX_W:0] wcnt;
  logic [mmmd_pkg::DIST_W-1:0]  runmax;
  logic                         accept;
  logic                         cfg_write;

  logic [2*mmmd_pkg::COORD_W-1:0] src_mem [mmmd_pkg::MAX_POINTS];
  logic [2*mmmd_pkg::COORD_W-1:0] tgt_mem [mmmd_pkg::MAX_POINTS];
  logic [2*mmmd_pkg::COORD_W-1:0] src_rd;
  logic [2*mmmd_pkg::COORD_W-1:0] tgt_rd;
  logic                           src_we;
  logic                           tgt_we;
  logic                           src_issue;
  logic                           tgt_issue;
  logic                           shift_d;
  logic                           src_valid_d;
  logic                           tgt_valid_d;

  mmmd_pkg::src_rec_t chain_in;
  mmmd_pkg::src_rec_t chain_out;
  mmmd_pkg::tgt_t     tgt_in;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == mmmd_pkg::REG_GRID_SIDE) ?
                     {{(mmmd_pkg::DATA_W-mmmd_pkg::SIDE_W){1'b0}}, grid_side} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= mmmd_pkg::SIDE_W'(1);
    end else if (cfg_write && paddr[2] == mmmd_pkg::REG_GRID_SIDE) begin
      grid_side <= pwdata[mmmd_pkg::SIDE_W-1:0];
    end
  end

  always_comb begin
    if (grid_side == '0) begin
      side_eff = mmmd_pkg::SIDE_W'(1);
    end else if (grid_side > mmmd_pkg::SIDE_W'(mmmd_pkg::MAX_SIDE)) begin
      side_eff = mmmd_pkg::SIDE_W'(mmmd_pkg::MAX_SIDE);
    end else begin
      side_eff = grid_side;
    end
  end

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy && (cell_kind != mmmd_pkg::KIND_NONE);
  assign col_inc = {1'b0, col} + mmmd_pkg::SIDE_W'(1);
  assign row_inc = {1'b0, row} + mmmd_pkg::SIDE_W'(1);
  assign src_we  = accept && (cell_kind == mmmd_pkg::KIND_SOURCE) &&
                   (scount < mmmd_pkg::CNT_W'(mmmd_pkg::MAX_POINTS));
  assign tgt_we  = accept && (cell_kind == mmmd_pkg::KIND_TARGET) &&
                   (tcount < mmmd_pkg::CNT_W'(mmmd_pkg::MAX_POINTS));
  assign src_idx   = base + {{(mmmd_pkg::BASE_W-mmmd_pkg::CELL_IDX_W){1'b0}}, kcnt};
  assign src_issue = (state == ST_LOAD);
  assign tgt_issue = (state == ST_STREAM) && (tcnt < tcount);

  // point stores
  always_ff @(posedge clk) begin
    if (src_we) begin
      src_mem[scount[mmmd_pkg::ADDR_W-1:0]] <= {row, col};
    end
    src_rd <= src_mem[src_idx[mmmd_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[tcount[mmmd_pkg::ADDR_W-1:0]] <= {row, col};
    end
    tgt_rd <= tgt_mem[tcnt[mmmd_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_d     <= 1'b0;
      src_valid_d <= 1'b0;
      tgt_valid_d <= 1'b0;
    end else begin
      shift_d     <= src_issue;
      src_valid_d <= src_issue && (src_idx < {1'b0, scount});
      tgt_valid_d <= tgt_issue;
    end
  end

  always_comb begin
    chain_in.valid = src_valid_d;
    chain_in.x     = src_rd[mmmd_pkg::COORD_W-1:0];
    chain_in.y     = src_rd[2*mmmd_pkg::COORD_W-1:mmmd_pkg::COORD_W];
    chain_in.best  = side_sq;
    tgt_in.valid   = tgt_valid_d;
    tgt_in.x       = tgt_rd[mmmd_pkg::COORD_W-1:0];
    tgt_in.y       = tgt_rd[2*mmmd_pkg::COORD_W-1:mmmd_pkg::COORD_W];
  end

  mmmd_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .shift   (shift_d),
    .rec_in  (chain_in),
    .rec_out (chain_out),
    .tgt_in  (tgt_in)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      col    <= '0;
      row    <= '0;
      scount <= '0;
      tcount <= '0;
      base   <= '0;
      kcnt   <= '0;
      tcnt   <= '0;
      wcnt   <= '0;
      runmax <= '0;
      side_sq <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (shift_d && chain_out.valid && chain_out.best > runmax) begin
        runmax <= chain_out.best;
      end
      case (state)
        ST_IDLE: begin
          if (src_we) begin
            scount <= scount + mmmd_pkg::CNT_W'(1);
          end
          if (tgt_we) begin
            tcount <= tcount + mmmd_pkg::CNT_W'(1);
          end
          if (accept) begin
            if (col_inc >= side_eff) begin
              col <= '0;
              if (row_inc >= side_eff) begin
                row     <= '0;
                base    <= '0;
                kcnt    <= '0;
                runmax  <= '0;
                side_sq <= mmmd_pkg::DIST_W'(side_eff * side_eff);
                state   <= ST_LOAD;
              end else begin
                row <= row_inc[mmmd_pkg::COORD_W-1:0];
              end
            end else begin
              col <= col_inc[mmmd_pkg::COORD_W-1:0];
            end
          end
        end
        ST_LOAD: begin
          kcnt <= kcnt + mmmd_pkg::CELL_IDX_W'(1);
          if (kcnt == mmmd_pkg::CELL_IDX_W'(mmmd_pkg::N_CELLS - 1)) begin
            tcnt <= '0;
            if (base < {1'b0, scount}) begin
              state <= ST_STREAM;
            end else begin
              state <= ST_SETTLE;
            end
          end
        end
        ST_STREAM: begin
          if (tgt_issue) begin
            tcnt <= tcnt + mmmd_pkg::CNT_W'(1);
          end else begin
            wcnt  <= '0;
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          wcnt <= wcnt + (mmmd_pkg::CELL_IDX_W+1)'(1);
          if (wcnt == (mmmd_pkg::CELL_IDX_W+1)'(mmmd_pkg::N_CELLS)) begin
            base  <= base + mmmd_pkg::BASE_W'(mmmd_pkg::N_CELLS);
            kcnt  <= '0;
            state <= ST_LOAD;
          end
        end
        ST_SETTLE: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          max_min_distance <= runmax;
          done   <= 1'b1;
          scount <= '0;
          tcount <= '0;
          state  <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one beat");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while search still running");
  a_result_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> max_min_distance <= side_sq)
    else $error("result above side squared");
  a_stream_batch: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STREAM) |-> (base < {1'b0, scount}))
    else $error("target stream without sources in batch");
  a_shift_quiet: assert property (@(posedge clk) disable iff (rst)
    shift_d |-> !tgt_valid_d)
    else $error("sources shifting while targets in flight");
`endif

endmodule

@@ dv/tb_top.sv @@
// Testbench for max_min_manhattan_distance_core: directed and random grids checked by a predictor.
`timescale 1ns / 100ps

module tb_top;
  import mmmd_pkg::*;

  localparam logic [PADDR_W-1:0] SIDE_ADDR = PADDR_W'(4 * int'(REG_GRID_SIDE));
  localparam int PHASE_CELLS = 120;

  typedef enum logic {ROW_CELL, ROW_SIDE} row_op_e;

  typedef struct packed {
    row_op_e           op;
    logic [7:0]        val;
    logic              chk;
    logic [DIST_W-1:0] want;
  } row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [1:0]        cell_kind = KIND_NONE;
  logic              busy;
  logic              done;
  logic [DIST_W-1:0] max_min_distance;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic [DIST_W-1:0] pending_dist[$];
  int                err_cnt = 0;
  int                idle_pct = 0;
  int                cell_cnt = 0;

  logic [6:0]        side_reg = 7'd1;
  int unsigned       src_col[MAX_POINTS];
  int unsigned       src_row[MAX_POINTS];
  int unsigned       tgt_col[MAX_POINTS];
  int unsigned       tgt_row[MAX_POINTS];
  int unsigned       src_cnt = 0;
  int unsigned       tgt_cnt = 0;
  int unsigned       col_pos = 0;
  int unsigned       row_pos = 0;

  row_t dir_rows [20] = '{
    '{ROW_CELL, 8'(KIND_SOURCE), 1'b1, 13'd1},
    '{ROW_CELL, 8'(KIND_TARGET), 1'b1, 13'd0},
    '{ROW_CELL, 8'(KIND_PLAIN),  1'b1, 13'd0},
    '{ROW_CELL, 8'(KIND_NONE),   1'b0, 13'd0},
    '{ROW_SIDE, 8'd0,            1'b0, 13'd0},
    '{ROW_CELL, 8'(KIND_SOURCE), 1'b1, 13'd1},
    '{ROW_SIDE, 8'd2,            1'b0, 13'd0},
    '{ROW_CELL, 8'(KIND_SOURCE), 1'b0, 13'd0},
    '{ROW_CELL, 8'(KIND_NONE),   1'b0, 13'd0},
    '{ROW_CELL, 8'(KIND_TARGET), 1'b0, 13'd0},
    '{ROW_CELL, 8'(KIND_PLAIN),  1'b0, 13'd0},
    '{ROW_CELL, 8'(KIND_TARGET), 1'b0, 13'd0},
    '{ROW_SIDE, 8'd127,          1'b0, 13'd0},
    '{ROW_CELL, 8'(KIND_SOURCE), 1'b0, 13'd0},
    '{ROW_CELL, 8'(KIND_PLAIN),  1'b0, 13'd0},
    '{ROW_CELL, 8'(KIND_SOURCE), 1'b0, 13'd0},
    '{ROW_SIDE, 8'd2,            1'b0, 13'd0},
    '{ROW_CELL, 8'(KIND_TARGET), 1'b0, 13'd0},
    '{ROW_CELL, 8'(KIND_PLAIN),  1'b0, 13'd0},
    '{ROW_CELL, 8'(KIND_PLAIN),  1'b0, 13'd0}
  };

  max_min_manhattan_distance_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .cell_kind        (cell_kind),
    .busy             (busy),
    .done             (done),
    .max_min_distance (max_min_distance),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  function automatic int unsigned side_in_use();
    if (side_reg == 7'd0) return 1;
    if (side_reg > MAX_SIDE) return MAX_SIDE;
    return side_reg;
  endfunction

  // Advance the grid by one cell unless the kind is none; on the last cell, compute
  // the max over sources of the nearest-target distance and clear the grid.
  function automatic bit grid_cell(input logic [1:0] kind, output logic [DIST_W-1:0] res);
    int unsigned eff, best, d, top;
    eff = side_in_use();
    res = '0;
    if (kind == KIND_NONE) return 1'b0;
    if (kind == KIND_SOURCE && src_cnt < MAX_POINTS) begin
      src_col[src_cnt] = col_pos;
      src_row[src_cnt] = row_pos;
      src_cnt++;
    end else if (kind == KIND_TARGET && tgt_cnt < MAX_POINTS) begin
      tgt_col[tgt_cnt] = col_pos;
      tgt_row[tgt_cnt] = row_pos;
      tgt_cnt++;
    end
    col_pos++;
    if (col_pos < eff) return 1'b0;
    col_pos = 0;
    row_pos++;
    if (row_pos < eff) return 1'b0;
    top = 0;
    for (int s = 0; s < src_cnt; s++) begin
      best = eff * eff;
      for (int t = 0; t < tgt_cnt; t++) begin
        d = ((src_col[s] > tgt_col[t]) ? src_col[s] - tgt_col[t] : tgt_col[t] - src_col[s]) +
            ((src_row[s] > tgt_row[t]) ? src_row[s] - tgt_row[t] : tgt_row[t] - src_row[s]);
        if (d < best) best = d;
      end
      if (best > top) top = best;
    end
    res = top[DIST_W-1:0];
    src_cnt = 0;
    tgt_cnt = 0;
    col_pos = 0;
    row_pos = 0;
    return 1'b1;
  endfunction

  function automatic logic [1:0] pick_kind(input int ps, input int pt);
    int r;
    if ($urandom_range(99) < 3) return KIND_NONE;
    r = $urandom_range(99);
    if (r < ps) return KIND_SOURCE;
    if (r < ps + pt) return KIND_TARGET;
    return KIND_PLAIN;
  endfunction

  task automatic send_cell(input logic [1:0] kind, input bit chk,
                           input logic [DIST_W-1:0] want, output bit fired);
    logic [DIST_W-1:0] expv;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cell_kind <= kind;
    @(posedge clk);
    while (busy) @(posedge clk);
    fired = grid_cell(kind, expv);
    if (fired) pending_dist = {pending_dist, (chk ? want : expv)};
    if (kind != KIND_NONE) cell_cnt++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_dist.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_side(input logic [6:0] val);
    logic [31:0] junk;
    junk = $urandom;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SIDE_ADDR;
    pwdata <= {junk[31:7], val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    side_reg = val;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {25'd0, val}) begin
      $error("grid_side readback expected %0d actual %0d", val, prdata);
      err_cnt++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Feed cells until the grid completes; optionally rewrite the side part way.
  task automatic run_grid(input int ps, input int pt, input int change_at);
    bit fired;
    int n;
    n = 0;
    do begin
      if (n == change_at) begin
        drain();
        write_side(7'($urandom_range(0, 8)));
      end
      send_cell(pick_kind(ps, pt), 1'b0, '0, fired);
      n++;
    end while (!fired);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_dist.size() == 0) begin
        $error("unexpected result max_min_distance=%0d", max_min_distance);
        err_cnt++;
      end else if (max_min_distance !== pending_dist[0]) begin
        $error("max_min_distance expected %0d actual %0d", pending_dist[0], max_min_distance);
        err_cnt++;
        void'(pending_dist.pop_front());
      end else begin
        void'(pending_dist.pop_front());
      end
    end
  end

  initial begin
    bit fired;
    int ps, pt, eff, change_at;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_SIDE) begin
        drain();
        write_side(dir_rows[i].val[6:0]);
      end else begin
        send_cell(dir_rows[i].val[1:0], dir_rows[i].chk, dir_rows[i].want, fired);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 30 : (ph == 1) ? 77 : 0;
      drain();
      cell_cnt = 0;
      while (cell_cnt < PHASE_CELLS) begin
        if ($urandom_range(99) < 30) begin
          drain();
          case ($urandom_range(9))
            0:       write_side(7'd0);
            1:       write_side(7'd1);
            2, 3:    write_side(7'($urandom_range(7, 16)));
            default: write_side(7'($urandom_range(2, 6)));
          endcase
        end
        case ($urandom_range(4))
          0:       begin ps = 30; pt = 30; end
          1:       begin ps = 40; pt = 0;  end
          2:       begin ps = 0;  pt = 40; end
          3:       begin ps = 60; pt = 5;  end
          default: begin ps = 33; pt = 33; end
        endcase
        eff = side_in_use();
        change_at = -1;
        if (eff > 1 && $urandom_range(99) < 8) change_at = $urandom_range(1, eff * eff - 1);
        run_grid(ps, pt, change_at);
      end
    end

    drain();
    repeat (2000) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
